@@ rtl/cwa_pkg.sv @@
`timescale 1ns / 1ps

package cwa_pkg;

  // Defaults for the top-level parameters.
  localparam int RADIUS_MAX_DEF  = 31;
  localparam int SAMPLE_BITS_DEF = 20;

  // The radius register is five bits wide, so a window never exceeds 63 samples.
  localparam int RADIUS_W = 5;
  localparam int WIN_W    = RADIUS_W + 1;

  // Saturating count of samples seen in the current sequence.
  localparam int SEEN_W   = 7;
  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // Configuration port: register index sits above the byte offset.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_RADIUS = 1'b0;

  // Work handed from the front end to the back end for one accepted beat.
  typedef struct packed {
    logic                emit_main;  // a result for the centre position is due
    logic                do_div;     // that position has a full window
    logic                last;       // the beat closed the sequence
    logic [RADIUS_W-1:0] extra;      // trailing positions to flush as -1
    logic [WIN_W-1:0]    win;        // window length, 2 * radius + 1
  } cwa_cmd_t;

endpackage

@@ rtl/centered_window_average_unit.sv @@
`timescale 1ns / 1ps

// Centred boxcar average over a stream of unsigned samples.
// Samples arrive as beats on the in_ channel; tdata carries the sample and
// tlast marks the final sample of a sequence. Each beat that completes a window
// radius samples past some position yields one beat on the out_ channel: the
// truncated mean of the 2 * radius + 1 samples centred there. Positions lacking
// a full window give all ones (-1). The beat carrying tlast also flushes every
// unanswered position as -1, and out_tlast marks the final result.
// The radius is written through the APB-style port at address 0; the user
// must write it only while the block is idle, as the block itself does not
// enforce it; a write starts a new sequence. The front end reads the ring
// when it accepts a beat, then updates the sum, takes no new beat until
// that update is done, and queues the work. The back end divides the window
// sum by the window length with a one-bit-per-cycle divider; a -1 for the
// centre position and each flushed -1 skip the divider.
// Sustained throughput is therefore set by the divider; while a division
// runs, the front end keeps taking beats until the queue fills.
// Reset clears the sequence state and the radius; no clearing pass is needed.
// When out_tready is low the result holds and the back end waits; the queue
// then fills and in_tready drops.

module centered_window_average_unit import cwa_pkg::*; #(
  parameter int RADIUS_MAX  = RADIUS_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int AVG_W      = SAMPLE_BITS + 1,
  localparam int OUT_W      = ((AVG_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // sample
  input  logic                  in_tlast,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // average (signed)
  output logic                  out_tlast,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SUM_W = SAMPLE_BITS + WIN_W;
  localparam int Q_W   = SUM_W + $bits(cwa_cmd_t);

  logic [RADIUS_W-1:0] radius_r;
  logic [RADIUS_W-1:0] r_eff;
  logic                cfg_wr;

  logic                q_push, q_pop, q_full, q_valid;
  cwa_cmd_t            f_cmd, b_cmd;
  logic [SUM_W-1:0]    f_sum, b_sum;
  logic [Q_W-1:0]      q_dout;
  logic                front_busy;
  logic [AVG_W-1:0]    avg;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_RADIUS);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_RADIUS) ? CFG_DATA_W'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_wr) begin
      radius_r <= pwdata[RADIUS_W-1:0];
    end
  end

  always_comb begin
    if (32'(radius_r) > 32'(RADIUS_MAX)) begin
      r_eff = RADIUS_W'(RADIUS_MAX);
    end else begin
      r_eff = radius_r;
    end
  end

  cwa_front #(
    .RADIUS_MAX  (RADIUS_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_eos    (in_tlast),
    .clear     (cfg_wr),
    .r_eff     (r_eff),
    .q_full    (q_full),
    .push      (q_push),
    .cmd       (f_cmd),
    .sum       (f_sum),
    .busy      (front_busy)
  );

  cwa_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({f_sum, f_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  assign b_sum = q_dout[Q_W-1 -: SUM_W];
  assign b_cmd = cwa_cmd_t'(q_dout[$bits(cwa_cmd_t)-1:0]);

  cwa_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .cmd       (b_cmd),
    .sum       (b_sum),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_avg   (avg),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_W'(avg);

  // The front end holds one beat at most, so a push never meets a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    front_busy |-> !in_tready)
    else $error("input ready while front end busy");

  // A result is either a non-negative mean or exactly -1.
  a_avg_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && avg[AVG_W-1]) |-> (&avg))
    else $error("negative average other than -1");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

endmodule

@@ rtl/cwa_queue.sv @@
`timescale 1ns / 1ps

module cwa_queue import cwa_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/cwa_front.sv @@
`timescale 1ns / 1ps

module cwa_front import cwa_pkg::*; #(
  parameter int RADIUS_MAX  = RADIUS_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int SUM_W      = SAMPLE_BITS + WIN_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_eos,
  input  logic                   clear,
  input  logic [RADIUS_W-1:0]    r_eff,
  input  logic                   q_full,
  output logic                   push,
  output cwa_cmd_t               cmd,
  output logic [SUM_W-1:0]       sum,
  output logic                   busy
);

  localparam int RING_DEPTH = 2 * RADIUS_MAX + 2;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CW         = (PTR_W > WIN_W ? PTR_W : WIN_W) + 1;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_r;
  logic [SAMPLE_BITS-1:0] s_r;
  logic                   eos_r;
  logic                   busy_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SEEN_W-1:0]      seen_r, seen_nxt;
  logic [PTR_W-1:0]       wp_r, wp_nxt;

  logic                   accept;
  logic [WIN_W-1:0]       win;
  logic [CW-1:0]          wp_ext, win_ext, old_ext;
  logic [PTR_W-1:0]       rd_addr;
  logic                   emit_main, do_div, drop_old;
  logic [SUM_W-1:0]       old_term;

  assign in_ready = !busy_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign busy     = busy_r;
  assign win      = {r_eff, 1'b1};

  // Address of the sample that leaves the window when this beat enters it.
  always_comb begin
    wp_ext  = CW'(wp_r);
    win_ext = CW'(win);
    if (wp_ext >= win_ext) begin
      old_ext = wp_ext - win_ext;
    end else begin
      old_ext = wp_ext + CW'(RING_DEPTH) - win_ext;
    end
    rd_addr = old_ext[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= ring[rd_addr];
    end
    if (busy_r) begin
      ring[wp_r] <= s_r;
    end
  end

  always_comb begin
    drop_old  = ({1'b0, seen_r} >= {2'b00, win});
    emit_main = ({1'b0, seen_r} >= {3'b000, r_eff});
    do_div    = ({1'b0, seen_r} >= {2'b00, r_eff, 1'b0});
    old_term  = drop_old ? SUM_W'(rd_r) : '0;
    sum_nxt   = sum_r + SUM_W'(s_r) - old_term;
    seen_nxt  = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
    wp_nxt    = (wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;

    cmd.emit_main = emit_main;
    cmd.do_div    = do_div;
    cmd.last      = eos_r;
    cmd.win       = win;
    if (!eos_r) begin
      cmd.extra = '0;
    end else if (emit_main) begin
      cmd.extra = r_eff;
    end else begin
      // Short sequence: every position seen so far is still unanswered.
      cmd.extra = RADIUS_W'(seen_r + 1'b1);
    end
  end

  assign push = busy_r && (emit_main || eos_r);
  assign sum  = sum_nxt;

  always_ff @(posedge clk) begin
    if (accept) begin
      s_r   <= in_sample;
      eos_r <= in_eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sum_r  <= '0;
      seen_r <= '0;
      wp_r   <= '0;
    end else begin
      busy_r <= accept;
      if (clear || (busy_r && eos_r)) begin
        sum_r  <= '0;
        seen_r <= '0;
        wp_r   <= '0;
      end else if (busy_r) begin
        sum_r  <= sum_nxt;
        seen_r <= seen_nxt;
        wp_r   <= wp_nxt;
      end
    end
  end

endmodule

@@ rtl/cwa_back.sv @@
`timescale 1ns / 1ps

module cwa_back import cwa_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int SUM_W      = SAMPLE_BITS + WIN_W,
  localparam int AVG_W      = SAMPLE_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cwa_cmd_t         cmd,
  input  logic [SUM_W-1:0] sum,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AVG_W-1:0] out_avg,
  output logic             out_last
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [RADIUS_W-1:0] extra_r, extra_nxt;
  logic                last_r, last_nxt;
  logic                use_q_r, use_q_nxt;
  logic [WIN_W-1:0]    win_r, win_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    quot_r, quot_nxt;
  logic [WIN_W-1:0]    rem_r, rem_nxt;
  logic                ov_r, ov_nxt;
  logic [AVG_W-1:0]    avg_r, avg_nxt;
  logic                olast_r, olast_nxt;

  logic                out_free;
  logic [WIN_W:0]      trial, diff;
  logic                q_bit;

  assign out_free  = !ov_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_avg   = avg_r;
  assign out_last  = olast_r;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    trial = {rem_r, quot_r[SUM_W-1]};
    diff  = trial - {1'b0, win_r};
    q_bit = (trial >= {1'b0, win_r});
  end

  always_comb begin
    state_nxt = state_r;
    extra_nxt = extra_r;
    last_nxt  = last_r;
    use_q_nxt = use_q_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r && !out_ready;
    avg_nxt   = avg_r;
    olast_nxt = olast_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          extra_nxt = cmd.extra;
          last_nxt  = cmd.last;
          use_q_nxt = cmd.do_div;
          win_nxt   = cmd.win;
          quot_nxt  = sum;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(SUM_W);
          if (cmd.emit_main && cmd.do_div) begin
            state_nxt = ST_DIV;
          end else if (cmd.emit_main) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_DIV: begin
        quot_nxt = {quot_r[SUM_W-2:0], q_bit};
        rem_nxt  = q_bit ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          avg_nxt   = use_q_r ? quot_r[AVG_W-1:0] : '1;
          olast_nxt = last_r && (extra_r == '0);
          state_nxt = (extra_r == '0) ? ST_IDLE : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          avg_nxt   = '1;
          olast_nxt = last_r && (extra_r == RADIUS_W'(1));
          extra_nxt = extra_r - 1'b1;
          if (extra_r == RADIUS_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    extra_r <= extra_nxt;
    last_r  <= last_nxt;
    use_q_r <= use_q_nxt;
    win_r   <= win_nxt;
    cnt_r   <= cnt_nxt;
    quot_r  <= quot_nxt;
    rem_r   <= rem_nxt;
    avg_r   <= avg_nxt;
    olast_r <= olast_nxt;
  end

endmodule

@@ tb/tb_centered_window_average_unit.sv @@
`timescale 1ns / 1ps

module tb_centered_window_average_unit;
  import cwa_pkg::*;

  localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
  localparam int AVG_W         = SAMPLE_W + 1;
  localparam int IN_W          = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W         = ((AVG_W + 7) / 8) * 8;
  localparam int RING_SLOTS    = 64;
  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = '1;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             last;
  } average_beat_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_HELD_OFF
  } ready_mode_t;

  // Running boxcar predictor and the queue of averages still owed by the block.
  class boxcar_predictor;
    logic [SAMPLE_W-1:0] ring [RING_SLOTS];
    logic [25:0]         window_sum;
    logic [SEEN_W-1:0]   seen;
    logic [5:0]          wr_ptr;
    logic [RADIUS_W-1:0] radius;
    average_beat_t       due_q[$];
    int                  errors;

    function new();
      radius = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      window_sum = '0;
      seen       = '0;
      wr_ptr     = '0;
    endfunction

    function void set_radius(logic [RADIUS_W-1:0] r);
      radius = r;
      restart();
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void take_sample(logic [SAMPLE_W-1:0] s, logic eos);
      int            win;
      int            pos;
      int            flush;
      int            k;
      average_beat_t b;
      win = 2 * radius + 1;
      pos = seen;
      ring[wr_ptr] = s;
      window_sum += s;
      if (pos >= win) begin
        window_sum -= ring[6'(wr_ptr - win)];
      end
      wr_ptr++;
      if (seen != SEEN_MAX) begin
        seen++;
      end
      flush = 0;
      if (eos) begin
        flush = (pos >= radius) ? int'(radius) : pos + 1;
      end
      if (pos >= radius) begin
        b.average = (pos >= 2 * radius) ? AVG_W'(window_sum / win) : '1;
        b.last    = eos && (flush == 0);
        due_q.push_back(b);
      end
      // Trailing positions never get a full window, so they flush as -1.
      for (k = 0; k < flush; k++) begin
        b.average = '1;
        b.last    = (k == flush - 1);
        due_q.push_back(b);
      end
      if (eos) begin
        restart();
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_average(logic [AVG_W-1:0] avg, logic last);
      average_beat_t want;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected average %0d", $signed(avg)));
        return;
      end
      want = due_q.pop_front();
      if (avg !== want.average) begin
        report_mismatch($sformatf("average %0d, wanted %0d",
                                  $signed(avg), $signed(want.average)));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("tlast %b, wanted %b", last, want.last));
      end
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata   = '0;   // sample
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;         // average (signed)
  logic                  out_tlast;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  boxcar_predictor predictor = new();

  int          burst_left  = 0;
  int          quiet_cycles = 0;
  ready_mode_t ready_mode  = READY_ALWAYS;
  int          ready_left  = 0;
  int          radius_plan [7] = '{31, 0, 1, 2, 5, 1, 0};

  centered_window_average_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predictor.take_sample(in_tdata[SAMPLE_W-1:0], in_tlast);
      end
      if (out_tvalid && out_tready) begin
        predictor.check_average(out_tdata[AVG_W-1:0], out_tlast);
      end
    end
  end

  // The receiver switches between several ready patterns for random stretches.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(5, 60);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   out_tready <= 1'b1;
      READY_COIN:     out_tready <= 1'($urandom_range(0, 1));
      READY_MOSTLY:   out_tready <= ($urandom_range(0, 7) != 0);
      default:        out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample(bit heavy);
    int roll;
    roll = $urandom_range(0, 7);
    if (heavy && roll != 0) begin
      return SAMPLE_FULL;
    end
    case (roll)
      0:       return '0;
      1:       return SAMPLE_FULL;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // The sender runs in bursts; within send_item, valid only drops in the gap between two bursts.
  task send_item(logic [SAMPLE_W-1:0] s, logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(s);
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task send_sequence(int len, bit close, int heavy_count);
    int k;
    for (k = 0; k < len; k++) begin
      send_item(pick_sample(k < heavy_count), close && (k == len - 1));
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Waits for the block to go idle, writes the radius and reads it back.
  task program_radius(logic [CFG_DATA_W-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RADIUS, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    predictor.set_radius(value[RADIUS_W-1:0]);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== CFG_DATA_W'(value[RADIUS_W-1:0])) begin
      predictor.report_mismatch($sformatf("radius read back as %0h", prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int i;
    int r;
    int len;
    int phase_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Radius zero after reset: samples pass straight through.
    send_item('0, 1'b0);
    send_item(SAMPLE_FULL, 1'b0);
    send_item(20'h5A5A5, 1'b1);
    send_item(20'hA5A5A, 1'b1);

    program_radius(32'd1);
    send_item(SAMPLE_FULL, 1'b0);
    send_item(SAMPLE_FULL, 1'b0);
    send_item(SAMPLE_FULL, 1'b0);
    send_item(20'h00001, 1'b1);
    send_item(20'h12345, 1'b1);

    // Leave a sequence open, then change the radius under it.
    program_radius(32'd2);
    send_item(20'h00007, 1'b0);
    send_item(20'h00008, 1'b0);
    send_item(20'h00009, 1'b0);

    // A sequence shorter than the widest window flushes entirely as -1.
    program_radius(32'd31);
    send_item(SAMPLE_FULL, 1'b0);
    send_item('0, 1'b0);
    send_item(20'h80000, 1'b0);
    send_item(20'h00001, 1'b1);

    // Bits above the radius field are ignored by the register.
    program_radius(32'hFFFF_FFE3);
    send_sequence(7, 1'b1, 7);

    radius_plan[4] = $urandom_range(3, 5);
    radius_plan[6] = $urandom_range(0, 4);
    for (i = 0; i < $size(radius_plan); i++) begin
      r = radius_plan[i];
      program_radius(($urandom() & ~32'h1F) | CFG_DATA_W'(r));
      if (r == 31) begin
        // A few full windows at the widest radius, starting near full scale.
        send_sequence(66, 1'b1, 40);
      end else begin
        phase_items = 0;
        while (phase_items < 4) begin
          if ($urandom_range(0, 9) < 7) begin
            len = $urandom_range(2 * r + 1, 2 * r + 4);
          end else begin
            len = $urandom_range(1, 2 * r + 1);
          end
          send_sequence(len, $urandom_range(0, 5) != 0, 0);
          phase_items += len;
        end
      end
    end

    drain();
    if (predictor.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cwa_pkg.sv
rtl/cwa_queue.sv
rtl/cwa_front.sv
rtl/cwa_back.sv
rtl/centered_window_average_unit.sv
tb/tb_centered_window_average_unit.sv
